>>> hw/rtl/owr_pkg.sv
`default_nettype none

package owr_pkg;

   // Widths of the configuration registers
   localparam int RstLowW   = 12;
   localparam int PresWaitW = 10;
   localparam int RstRecW   = 12;
   localparam int ShortLowW = 4;
   localparam int SlotW     = 8;
   localparam int GapW      = 16;
   localparam int ConvW     = 20;
   localparam int DurW      = 20;   // widest duration
   localparam int CsrIdxW   = 3;
   localparam int CsrDataW  = 20;

   localparam int TickCountBitsDef = 20;

   // Register indexes
   localparam logic [CsrIdxW-1:0] REG_RST_LOW   = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_PRES_WAIT = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_RST_REC   = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_SHORT_LOW = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_SLOT      = 3'd4;
   localparam logic [CsrIdxW-1:0] REG_GAP       = 3'd5;
   localparam logic [CsrIdxW-1:0] REG_CONV      = 3'd6;

   // Register reset values
   localparam logic [RstLowW-1:0]   RST_LOW_DEF   = 12'd480;
   localparam logic [PresWaitW-1:0] PRES_WAIT_DEF = 10'd80;
   localparam logic [RstRecW-1:0]   RST_REC_DEF   = 12'd400;
   localparam logic [ShortLowW-1:0] SHORT_LOW_DEF = 4'd1;
   localparam logic [SlotW-1:0]     SLOT_DEF      = 8'd50;
   localparam logic [GapW-1:0]      GAP_DEF       = 16'd1000;
   localparam logic [ConvW-1:0]     CONV_DEF      = 20'd800000;

   // 1-Wire ROM and function commands
   localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
   localparam logic [7:0] CMD_CONVERT  = 8'h44;
   localparam logic [7:0] CMD_READ_SP  = 8'hBE;

   typedef struct packed {
      logic [RstLowW-1:0]   rst_low;
      logic [PresWaitW-1:0] pres_wait;
      logic [RstRecW-1:0]   rst_rec;
      logic [ShortLowW-1:0] short_low;
      logic [SlotW-1:0]     slot;
      logic [GapW-1:0]      gap;
      logic [ConvW-1:0]     conv;
   } cfg_type;

   // Command byte sent for each of the four write steps
   function automatic logic [7:0] cmd_byte(input logic [1:0] step);
      logic [7:0] b;
      case (step)
         2'd0:    b = CMD_SKIP_ROM;
         2'd1:    b = CMD_CONVERT;
         2'd2:    b = CMD_SKIP_ROM;
         default: b = CMD_READ_SP;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/one_wire_temperature_reader_top.sv
// Channel | Dir | Beat fields
// req_    | in  | tdata[0] start_req, tdata[1] line_level
// rsp_    | out | tdata[0] drive_low, [1] busy_res, [2] done_res,
//         |     | [3] presence_seen, [19:4] temperature_raw
// csr_    | in  | csr_index register number, csr_wdata value
//
// Each req beat is one bus tick; the sequencer state advances on the beat
// and its response is registered into the output register on the same clock edge.
// One beat per clock is sustained while rsp_tready holds; the output register is the only stage.
// A new req beat is taken while the held response drains (rsp_tready).
// Reset is synchronous; it restores the register defaults and idles the bus.
`default_nettype none

module one_wire_temperature_reader_top
   import owr_pkg::*;
#(
   parameter int TICK_COUNT_BITS = TickCountBitsDef
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [7:0]          req_tdata,   // start_req, line_level
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [23:0]              rsp_tdata,   // drive_low, busy_res, done_res,
                                                 // presence_seen, temperature_raw
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [CsrDataW-1:0] csr_wdata
);

   localparam int TcW  = TICK_COUNT_BITS;
   localparam int CmpW = (TcW > DurW) ? TcW : DurW;

   // Phase codes
   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_RST_LOW  = 4'd1;
   localparam logic [3:0] PH_RST_WAIT = 4'd2;
   localparam logic [3:0] PH_RST_REC  = 4'd3;
   localparam logic [3:0] PH_GAP      = 4'd4;
   localparam logic [3:0] PH_WR_LOW   = 4'd5;
   localparam logic [3:0] PH_WR_TAIL  = 4'd6;
   localparam logic [3:0] PH_RD_LOW   = 4'd7;
   localparam logic [3:0] PH_RD_TAIL  = 4'd8;
   localparam logic [3:0] PH_RECOV    = 4'd9;
   localparam logic [3:0] PH_CONV     = 4'd10;

   cfg_type cfg;

   owr_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   logic [3:0]     phase_ff, phase_in;
   logic [TcW-1:0] tick_ff, tick_in;
   logic [2:0]     bit_ff, bit_in;
   logic [2:0]     step_ff, step_in;
   logic [7:0]     shift_ff, shift_in;
   logic [7:0]     low_ff, low_in;
   logic [15:0]    word_ff, word_in;
   logic           pres_ff, pres_in;
   logic           rsp_valid_ff;
   logic [23:0]    rsp_data_ff;

   logic           accept;
   logic           start_req, line_level;
   logic           cur_bit, drive, busy, done_now;
   logic [DurW-1:0] dur_sel, lim;
   logic [CmpW-1:0] lim_ext, lim_clamp, cnt_max;
   logic           hit;
   logic [TcW-1:0] tick_next;
   logic           go_byte, go_slot;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign start_req  = req_tdata[0];
   assign line_level = req_tdata[1];
   assign cur_bit    = shift_ff[bit_ff];

   // Duration for the running phase
   always_comb begin
      case (phase_ff)
         PH_RST_LOW:  dur_sel = DurW'(cfg.rst_low);
         PH_RST_WAIT: dur_sel = DurW'(cfg.pres_wait);
         PH_RST_REC:  dur_sel = DurW'(cfg.rst_rec);
         PH_GAP:      dur_sel = DurW'(cfg.gap);
         PH_WR_LOW:   dur_sel = cur_bit ? DurW'(cfg.short_low) : DurW'(cfg.slot);
         PH_WR_TAIL:  dur_sel = DurW'(cfg.slot);
         PH_RD_LOW:   dur_sel = DurW'(cfg.short_low);
         PH_RD_TAIL:  dur_sel = DurW'(cfg.slot);
         PH_CONV:     dur_sel = cfg.conv;
         default:     dur_sel = '0;
      endcase
   end

   // Tick timer: zero acts as one tick, limit clamps at counter max
   always_comb begin
      lim       = (dur_sel != '0) ? dur_sel - DurW'(1) : '0;
      lim_ext   = CmpW'(lim);
      cnt_max   = CmpW'({TcW{1'b1}});
      lim_clamp = (lim_ext > cnt_max) ? cnt_max : lim_ext;
      hit       = CmpW'(tick_ff) >= lim_clamp;
      tick_next = hit ? '0 : tick_ff + TcW'(1);
   end

   // Sequencer next state
   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      step_in  = step_ff;
      shift_in = shift_ff;
      low_in   = low_ff;
      word_in  = word_ff;
      pres_in  = pres_ff;
      done_now = 1'b0;
      go_byte  = 1'b0;
      go_slot  = 1'b0;
      drive    = (phase_ff == PH_RST_LOW) || (phase_ff == PH_WR_LOW) ||
                 (phase_ff == PH_RD_LOW);
      busy     = (phase_ff != PH_IDLE);

      case (phase_ff)
         PH_IDLE: begin
            if (start_req) begin
               step_in  = 3'd0;
               phase_in = PH_RST_LOW;
               tick_in  = '0;
            end
         end
         PH_RST_LOW: begin
            tick_in = tick_next;
            if (hit) phase_in = PH_RST_WAIT;
         end
         PH_RST_WAIT: begin
            tick_in = tick_next;
            if (hit) begin
               pres_in  = !line_level;
               phase_in = PH_RST_REC;
            end
         end
         PH_RST_REC: begin
            tick_in = tick_next;
            if (hit) begin
               if (cfg.gap != '0) phase_in = PH_GAP;
               else go_byte = 1'b1;
            end
         end
         PH_GAP: begin
            tick_in = tick_next;
            if (hit) go_byte = 1'b1;
         end
         PH_WR_LOW: begin
            tick_in = tick_next;
            if (hit) phase_in = cur_bit ? PH_WR_TAIL : PH_RECOV;
         end
         PH_WR_TAIL: begin
            tick_in = tick_next;
            if (hit) phase_in = PH_RECOV;
         end
         PH_RD_LOW: begin
            tick_in = tick_next;
            if (hit) phase_in = PH_RD_TAIL;
         end
         PH_RD_TAIL: begin
            // sample on the first released tick
            if (tick_ff == '0 && line_level) shift_in[bit_ff] = 1'b1;
            tick_in = tick_next;
            if (hit) phase_in = PH_RECOV;
         end
         PH_RECOV: begin
            tick_in = '0;
            if (bit_ff == 3'd7) begin
               // end of byte
               case (step_ff)
                  3'd0, 3'd2, 3'd3: begin
                     step_in = step_ff + 3'd1;
                     go_byte = 1'b1;
                  end
                  3'd1: begin
                     phase_in = PH_CONV;
                  end
                  3'd4: begin
                     low_in  = shift_ff;
                     step_in = 3'd5;
                     go_byte = 1'b1;
                  end
                  3'd5: begin
                     word_in  = {shift_ff, low_ff};
                     done_now = 1'b1;
                     step_in  = 3'd0;
                     phase_in = PH_IDLE;
                  end
                  default: begin
                     step_in  = 3'd0;
                     phase_in = PH_IDLE;
                  end
               endcase
            end else begin
               bit_in  = bit_ff + 3'd1;
               go_slot = 1'b1;
            end
         end
         PH_CONV: begin
            tick_in = tick_next;
            if (hit) begin
               step_in  = 3'd2;
               phase_in = PH_RST_LOW;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            tick_in  = '0;
            step_in  = 3'd0;
         end
      endcase

      // Byte start loads the command (or clears for a read), then a slot
      if (go_byte) begin
         bit_in   = 3'd0;
         shift_in = (step_in < 3'd4) ? cmd_byte(step_in[1:0]) : 8'h00;
      end
      if (go_byte || go_slot) begin
         phase_in = (step_in >= 3'd4) ? PH_RD_LOW : PH_WR_LOW;
         tick_in  = '0;
      end
   end

   // State registers, advanced once per accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         bit_ff   <= '0;
         step_ff  <= '0;
         shift_ff <= '0;
         low_ff   <= '0;
         word_ff  <= '0;
         pres_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         step_ff  <= step_in;
         shift_ff <= shift_in;
         low_ff   <= low_in;
         word_ff  <= word_in;
         pres_ff  <= pres_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= {4'd0, word_in, pres_in, done_now, busy, drive};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/owr_cfg.sv
`default_nettype none

module owr_cfg
   import owr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [CsrDataW-1:0] csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Register write decode, value masked to register width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_RST_LOW:   cfg_in.rst_low   = csr_wdata[RstLowW-1:0];
            REG_PRES_WAIT: cfg_in.pres_wait = csr_wdata[PresWaitW-1:0];
            REG_RST_REC:   cfg_in.rst_rec   = csr_wdata[RstRecW-1:0];
            REG_SHORT_LOW: cfg_in.short_low = csr_wdata[ShortLowW-1:0];
            REG_SLOT:      cfg_in.slot      = csr_wdata[SlotW-1:0];
            REG_GAP:       cfg_in.gap       = csr_wdata[GapW-1:0];
            REG_CONV:      cfg_in.conv      = csr_wdata[ConvW-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rst_low   <= RST_LOW_DEF;
         cfg_ff.pres_wait <= PRES_WAIT_DEF;
         cfg_ff.rst_rec   <= RST_REC_DEF;
         cfg_ff.short_low <= SHORT_LOW_DEF;
         cfg_ff.slot      <= SLOT_DEF;
         cfg_ff.gap       <= GAP_DEF;
         cfg_ff.conv      <= CONV_DEF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire
